>>> design/ilru_pkg.sv
`default_nettype none

package ilru_pkg;

    // Field widths of one transaction
    localparam int ENTRY_W = 6;
    localparam int COUNT_W = 7;

    // Action codes
    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_UNLINK = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the incoming transaction
        logic link_new;    // write older link of new entry, newer link of old head
        logic push_fin;    // terminate new entry's newer link, move head
        logic unlink_fin;  // splice neighbours together, drop the mark
        logic clear;       // empty the list
        logic report;      // present the result
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic push_ok;     // push of an in-range entry that is not idle
        logic unlink_ok;   // unlink of an in-range entry that is idle
        logic clear_req;   // clear action
    } t_sts;

endpackage

`default_nettype wire

>>> design/ilru_ram.sv
`default_nettype none

module ilru_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/ilru_dpath.sv
`default_nettype none

module ilru_dpath
    import ilru_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_action,
    input  wire logic [ENTRY_W-1:0]   i_entry,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output logic                      o_oldest_valid,
    output logic [ENTRY_W-1:0]        o_oldest_entry,
    output logic [COUNT_W-1:0]        o_idle_count
);

    // Only indices that the entry field can reach get storage
    localparam int SLOTS  = (ENTRIES < (1 << ENTRY_W)) ? ENTRIES : (1 << ENTRY_W);
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0]  NONE    = LINK_W'(SLOTS);
    localparam logic [ENTRY_W:0]   SLOTS_X = (ENTRY_W + 1)'(SLOTS);
    localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(SLOTS);

    // Captured transaction
    t_action              r_action;
    logic [ENTRY_W-1:0]   r_entry;

    // List registers
    logic [SLOTS-1:0]     r_mark,  n_mark;
    logic [LINK_W-1:0]    r_head,  n_head;
    logic [LINK_W-1:0]    r_tail,  n_tail;
    logic [CNT_W-1:0]     r_count, n_count;

    // Link memories
    logic                 newer_we,    older_we;
    logic [IDX_W-1:0]     newer_waddr, older_waddr;
    logic [LINK_W-1:0]    newer_wdata, older_wdata;
    logic [LINK_W-1:0]    newer_rdata, older_rdata;

    logic [IDX_W-1:0]     idx;
    logic [LINK_W-1:0]    entry_link;
    logic                 in_range;
    logic                 is_idle;
    logic                 head_valid;
    logic                 nw_valid;
    logic                 od_valid;

    // Hold the transaction for the whole operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_entry  <= i_entry;
        end
    end

    assign idx        = r_entry[IDX_W-1:0];
    assign entry_link = LINK_W'(idx);
    assign in_range   = ({1'b0, r_entry} < SLOTS_X);
    assign is_idle    = in_range && r_mark[idx];
    assign head_valid = (r_head != NONE);
    assign nw_valid   = (newer_rdata != NONE);
    assign od_valid   = (older_rdata != NONE);

    // Decode the captured action
    always_comb begin
        o_sts.push_ok   = (r_action == ACT_PUSH) && in_range && !is_idle;
        o_sts.unlink_ok = (r_action == ACT_UNLINK) && is_idle;
        o_sts.clear_req = (r_action == ACT_CLEAR);
    end

    // Link writes: newer side
    always_comb begin
        newer_we    = 1'b0;
        newer_waddr = idx;
        newer_wdata = NONE;
        if (i_cmd.link_new) begin
            newer_we    = head_valid;
            newer_waddr = r_head[IDX_W-1:0];
            newer_wdata = entry_link;
        end else if (i_cmd.push_fin) begin
            newer_we    = 1'b1;
            newer_waddr = idx;
            newer_wdata = NONE;
        end else if (i_cmd.unlink_fin) begin
            newer_we    = od_valid;
            newer_waddr = older_rdata[IDX_W-1:0];
            newer_wdata = newer_rdata;
        end
    end

    // Link writes: older side
    always_comb begin
        older_we    = 1'b0;
        older_waddr = idx;
        older_wdata = r_head;
        if (i_cmd.link_new) begin
            older_we    = 1'b1;
            older_waddr = idx;
            older_wdata = r_head;
        end else if (i_cmd.unlink_fin) begin
            older_we    = nw_valid;
            older_waddr = newer_rdata[IDX_W-1:0];
            older_wdata = older_rdata;
        end
    end

    ilru_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (newer_we),
        .i_waddr (newer_waddr),
        .i_wdata (newer_wdata),
        .i_raddr (idx),
        .o_rdata (newer_rdata)
    );

    ilru_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (older_we),
        .i_waddr (older_waddr),
        .i_wdata (older_wdata),
        .i_raddr (idx),
        .o_rdata (older_rdata)
    );

    // Advance head, tail, count and marks
    always_comb begin
        n_mark  = r_mark;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.clear) begin
            n_mark  = '0;
            n_head  = NONE;
            n_tail  = NONE;
            n_count = '0;
        end else if (i_cmd.push_fin) begin
            n_mark[idx] = 1'b1;
            n_head      = entry_link;
            if (r_tail == NONE) begin
                n_tail = entry_link;
            end
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.unlink_fin) begin
            n_mark[idx] = 1'b0;
            if (!nw_valid) begin
                n_head = older_rdata;
            end
            if (!od_valid) begin
                n_tail = newer_rdata;
            end
            if (r_count != '0) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= '0;
            r_head  <= NONE;
            r_tail  <= NONE;
            r_count <= '0;
        end else begin
            r_mark  <= n_mark;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Result fields
    assign o_oldest_valid = (r_tail != NONE);
    assign o_oldest_entry = o_oldest_valid ? ENTRY_W'(r_tail[IDX_W-1:0]) : '0;
    assign o_idle_count   = COUNT_W'(r_count);

`ifndef SYNTHESIS
    a_count_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_mark)))
        else $error("idle count differs from number of idle marks");

    a_head_tail_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE) == (r_tail == NONE))
        else $error("head and tail disagree on list emptiness");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail == NONE) == (r_count == '0))
        else $error("tail and count disagree on list emptiness");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("idle count exceeds number of entries");
`endif

endmodule

`default_nettype wire

>>> design/ilru_ctrl.sv
`default_nettype none

module ilru_ctrl
    import ilru_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_sts   i_sts,
    output t_cmd        o_cmd,
    output logic        o_busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_PUSH   = 5'b00100,
        S_UNLINK = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    // Sequence one transaction
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.link_new = i_sts.push_ok;
                o_cmd.clear    = i_sts.clear_req;
                if (i_sts.push_ok) begin
                    n_state = S_PUSH;
                end else if (i_sts.unlink_ok) begin
                    n_state = S_UNLINK;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_PUSH: begin
                o_cmd.push_fin = 1'b1;
                n_state        = S_REPORT;
            end
            S_UNLINK: begin
                o_cmd.unlink_fin = 1'b1;
                n_state          = S_REPORT;
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_start_leads_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_DECODE))
        else $error("accepted transaction did not enter decode");

    a_report_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push_fin || o_cmd.unlink_fin) |=> o_cmd.report)
        else $error("list update not followed by result");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.link_new, o_cmd.clear, o_cmd.push_fin, o_cmd.unlink_fin,
                  o_cmd.report, o_cmd.load}))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

`default_nettype wire

>>> design/idle_lru_list.sv
// Result strobe: raised in the report state, which comes after decode and the push or
// unlink state for push and unlink, and right after decode for clear, query and ignored
// actions. A new transaction is taken only while not busy; busy covers the whole sequence,
// set by the link-memory read and the two writes a push needs on the newer-link memory.
// Reset: synchronous, empties the list (no idle marks, count zero); links are not cleared.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module idle_lru_list
    import ilru_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_action,
    input  wire logic [ENTRY_W-1:0]   i_entry,
    output logic                      o_valid,
    output logic                      o_oldest_valid,
    output logic [ENTRY_W-1:0]        o_oldest_entry,
    output logic [COUNT_W-1:0]        o_idle_count
);

    t_cmd cmd;
    t_sts sts;

    ilru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ilru_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_entry        (i_entry),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_oldest_valid (o_oldest_valid),
        .o_oldest_entry (o_oldest_entry),
        .o_idle_count   (o_idle_count)
    );

    assign o_valid = cmd.report;

endmodule

`default_nettype wire
